// File: hw/rtl/alu_with_status_flags_core_assert.svh
// Assertion macros for the status-flag ALU.
// Included by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef ALU_WITH_STATUS_FLAGS_CORE_ASSERT_SVH
`define ALU_WITH_STATUS_FLAGS_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define AFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define AFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AFS_ASSERT_IMP(lbl, ante, cons, msg)
`define AFS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/afs_pkg.sv
// Types and constants for the status-flag ALU.
// No dependencies; imported by afs_exec and alu_with_status_flags_core.
package afs_pkg;

  typedef enum logic [3:0] {
    OP_ADD8     = 4'd0,
    OP_SUB8     = 4'd1,
    OP_AND      = 4'd2,
    OP_OR       = 4'd3,
    OP_XOR      = 4'd4,
    OP_CMP      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_ADD16    = 4'd8,
    OP_ADC16    = 4'd9,
    OP_SBC16    = 4'd10,
    OP_ROTFLAGS = 4'd11,
    OP_IOFLAGS  = 4'd12,
    OP_COND     = 4'd13,
    OP_CLEARQ   = 4'd14
  } op_t;

  // Flag bit positions: S Z Y H X P N C at 7..0.
  localparam int FL_S = 7;
  localparam int FL_Z = 6;
  localparam int FL_Y = 5;
  localparam int FL_H = 4;
  localparam int FL_X = 3;
  localparam int FL_P = 2;
  localparam int FL_N = 1;
  localparam int FL_C = 0;

  // Condition pairs selected by cond_code[2:1].
  localparam logic [1:0] CC_ZERO   = 2'd0;
  localparam logic [1:0] CC_CARRY  = 2'd1;
  localparam logic [1:0] CC_PARITY = 2'd2;
  localparam logic [1:0] CC_SIGN   = 2'd3;

  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  flags;
    logic        met;
    logic [15:0] pointer;
    logic        set_q;
    logic        clr_q;
  } exec_out_t;

endpackage

// File: hw/rtl/afs_exec.sv
// Combinational execute stage: one ALU operation against the current flag state.
// Depends on afs_pkg.
module afs_exec (
  input  logic [3:0]        opcode,
  input  logic [15:0]       operand_a,
  input  logic [15:0]       operand_b,
  input  logic              carry_in,
  input  logic [2:0]        cond_code,
  input  logic              force_sign_clear,
  input  logic              io_data_top,
  input  logic [7:0]        flags_cur,
  input  logic [15:0]       pointer_cur,
  output afs_pkg::exec_out_t ex
);
  import afs_pkg::*;

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [8:0]  sum9;
  logic [8:0]  dif9;
  logic [7:0]  logic_r;
  logic [7:0]  inc_r;
  logic [7:0]  dec_r;
  logic [16:0] sum17;
  logic [16:0] dif17;
  logic [15:0] ptr_inc;
  logic        sub_cin;
  logic        add16_cin;
  logic        cc_flag;

  assign a8        = operand_a[7:0];
  assign b8        = operand_b[7:0];
  assign sub_cin   = (opcode == OP_SUB8) ? carry_in : 1'b0;
  assign add16_cin = (opcode == OP_ADC16) ? carry_in : 1'b0;
  assign sum9      = {1'b0, a8} + {1'b0, b8} + {8'd0, carry_in};
  assign dif9      = {1'b0, a8} - {1'b0, b8} - {8'd0, sub_cin};
  assign inc_r     = b8 + 8'd1;
  assign dec_r     = b8 - 8'd1;
  assign sum17     = {1'b0, operand_a} + {1'b0, operand_b} + {16'd0, add16_cin};
  assign dif17     = {1'b0, operand_a} - {1'b0, operand_b} - {16'd0, carry_in};
  assign ptr_inc   = operand_a + 16'd1;

  always_comb begin
    case (opcode)
      OP_AND:  logic_r = a8 & b8;
      OP_OR:   logic_r = a8 | b8;
      OP_XOR:  logic_r = a8 ^ b8;
      default: logic_r = b8;
    endcase
  end

  always_comb begin
    case (cond_code[2:1])
      CC_ZERO:   cc_flag = flags_cur[FL_Z];
      CC_CARRY:  cc_flag = flags_cur[FL_C];
      CC_PARITY: cc_flag = flags_cur[FL_P];
      CC_SIGN:   cc_flag = flags_cur[FL_S];
      default:   cc_flag = 1'b0;
    endcase
  end

  always_comb begin
    ex         = '0;
    ex.flags   = flags_cur;
    ex.pointer = pointer_cur;
    ex.set_q   = 1'b1;
    case (opcode)
      OP_ADD8: begin
        ex.result       = {8'd0, sum9[7:0]};
        ex.flags        = '0;
        ex.flags[FL_S]  = sum9[7];
        ex.flags[FL_Z]  = (sum9[7:0] == 8'd0);
        ex.flags[FL_Y]  = sum9[5];
        ex.flags[FL_H]  = a8[4] ^ b8[4] ^ sum9[4];
        ex.flags[FL_X]  = sum9[3];
        ex.flags[FL_P]  = ~(a8[7] ^ b8[7]) & (a8[7] ^ sum9[7]);
        ex.flags[FL_C]  = sum9[8];
      end
      OP_SUB8, OP_CMP: begin
        ex.result       = {8'd0, dif9[7:0]};
        ex.flags        = '0;
        ex.flags[FL_S]  = dif9[7];
        ex.flags[FL_Z]  = (dif9[7:0] == 8'd0);
        ex.flags[FL_H]  = a8[4] ^ b8[4] ^ dif9[4];
        ex.flags[FL_P]  = (a8[7] ^ b8[7]) & (a8[7] ^ dif9[7]);
        ex.flags[FL_N]  = 1'b1;
        ex.flags[FL_C]  = dif9[8];
        // Compare takes X and Y from the operand, not the difference.
        ex.flags[FL_Y]  = (opcode == OP_CMP) ? b8[5] : dif9[5];
        ex.flags[FL_X]  = (opcode == OP_CMP) ? b8[3] : dif9[3];
      end
      OP_AND, OP_OR, OP_XOR, OP_ROTFLAGS: begin
        ex.result       = (opcode == OP_ROTFLAGS) ? 16'd0 : {8'd0, logic_r};
        ex.flags        = '0;
        ex.flags[FL_S]  = logic_r[7] & ~((opcode == OP_ROTFLAGS) & force_sign_clear);
        ex.flags[FL_Z]  = (logic_r == 8'd0);
        ex.flags[FL_Y]  = logic_r[5];
        ex.flags[FL_H]  = (opcode == OP_AND);
        ex.flags[FL_X]  = logic_r[3];
        ex.flags[FL_P]  = ~(^logic_r);
        ex.flags[FL_C]  = (opcode == OP_ROTFLAGS) ? flags_cur[FL_C] : 1'b0;
      end
      OP_INC: begin
        ex.result       = {8'd0, inc_r};
        ex.flags        = '0;
        ex.flags[FL_S]  = inc_r[7];
        ex.flags[FL_Z]  = (inc_r == 8'd0);
        ex.flags[FL_Y]  = inc_r[5];
        ex.flags[FL_H]  = (b8[3:0] == 4'hF);
        ex.flags[FL_X]  = inc_r[3];
        ex.flags[FL_P]  = (b8 == 8'h7F);
        ex.flags[FL_C]  = flags_cur[FL_C];
      end
      OP_DEC: begin
        ex.result       = {8'd0, dec_r};
        ex.flags        = '0;
        ex.flags[FL_S]  = dec_r[7];
        ex.flags[FL_Z]  = (dec_r == 8'd0);
        ex.flags[FL_Y]  = dec_r[5];
        ex.flags[FL_H]  = (b8[3:0] == 4'h0);
        ex.flags[FL_X]  = dec_r[3];
        ex.flags[FL_P]  = (b8 == 8'h80);
        ex.flags[FL_N]  = 1'b1;
        ex.flags[FL_C]  = flags_cur[FL_C];
      end
      OP_ADD16, OP_ADC16: begin
        ex.result       = sum17[15:0];
        ex.pointer      = ptr_inc;
        // Plain add16 keeps S, Z and P.
        if (opcode == OP_ADC16) begin
          ex.flags[FL_S] = sum17[15];
          ex.flags[FL_Z] = (sum17[15:0] == 16'd0);
          ex.flags[FL_P] = ~(operand_a[15] ^ operand_b[15]) & (operand_a[15] ^ sum17[15]);
        end
        ex.flags[FL_Y]  = sum17[13];
        ex.flags[FL_H]  = operand_a[12] ^ operand_b[12] ^ sum17[12];
        ex.flags[FL_X]  = sum17[11];
        ex.flags[FL_N]  = 1'b0;
        ex.flags[FL_C]  = sum17[16];
      end
      OP_SBC16: begin
        ex.result       = dif17[15:0];
        ex.pointer      = ptr_inc;
        ex.flags[FL_S]  = dif17[15];
        ex.flags[FL_Z]  = (dif17[15:0] == 16'd0);
        ex.flags[FL_Y]  = dif17[13];
        ex.flags[FL_H]  = operand_a[12] ^ operand_b[12] ^ dif17[12];
        ex.flags[FL_X]  = dif17[11];
        ex.flags[FL_P]  = (operand_a[15] ^ operand_b[15]) & (operand_a[15] ^ dif17[15]);
        ex.flags[FL_N]  = 1'b1;
        ex.flags[FL_C]  = dif17[16];
      end
      OP_IOFLAGS: begin
        ex.flags[FL_H]  = |operand_b[15:8];
        ex.flags[FL_C]  = |operand_b[15:8];
        ex.flags[FL_P]  = ~(^({5'd0, operand_b[2:0]} ^ a8));
        ex.flags[FL_N]  = io_data_top;
      end
      OP_COND: begin
        ex.met   = cond_code[0] ? cc_flag : ~cc_flag;
        ex.set_q = 1'b0;
      end
      OP_CLEARQ: begin
        ex.set_q = 1'b0;
        ex.clr_q = 1'b1;
      end
      default: begin
        ex.set_q = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/alu_with_status_flags_core.sv
// Top level of the status-flag ALU: input register, flag/pointer state, result register.
// Depends on afs_pkg, afs_exec and alu_with_status_flags_core_assert.svh.
//
// Usage:
//   Input channel in_* (valid/ready) carries opcode, operands, carry, condition
//   code and the rotate/I/O side bits. Output channel out_* (valid/ready) returns
//   result, flags_out, condition_met and pointer_out, one item per input item.
//   An accepted item passes the input register, then the result register, to out_*.
//   Throughput: one item per cycle while out_ready is high. The input register
//   and the result register form a two-entry pipeline, and the flag state is
//   updated as each item moves from the input register to the result register,
//   so the next item sees the flags its predecessor left.
//   When the receiver stalls, the result register holds; one more item can be
//   accepted into the input register, after which in_ready drops.
//   Reset (rst_n low, synchronous) empties both registers and clears the flag
//   register, the Q copy and the memory pointer.
module alu_with_status_flags_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_opcode,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  input  logic        in_carry_in,
  input  logic [2:0]  in_cond_code,
  input  logic        in_force_sign_clear,
  input  logic        in_io_data_top,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result,
  output logic [7:0]  out_flags_out,
  output logic        out_condition_met,
  output logic [15:0] out_pointer_out
);
  import afs_pkg::*;

  `include "alu_with_status_flags_core_assert.svh"

  logic        s1_valid_r;
  logic [3:0]  s1_opcode_r;
  logic [15:0] s1_a_r;
  logic [15:0] s1_b_r;
  logic        s1_cin_r;
  logic [2:0]  s1_cc_r;
  logic        s1_fsc_r;
  logic        s1_iotop_r;

  logic [7:0]  flags_r;
  logic [7:0]  q_r;
  logic [15:0] ptr_r;

  logic        out_valid_r;
  logic [15:0] out_result_r;
  logic [7:0]  out_flags_r;
  logic        out_met_r;
  logic [15:0] out_ptr_r;

  logic        out_free;
  logic        s1_adv;
  logic        in_fire;
  exec_out_t   ex;

  assign out_free = ~out_valid_r | out_ready;
  assign s1_adv   = s1_valid_r & out_free;
  assign in_ready = ~s1_valid_r | out_free;
  assign in_fire  = in_valid & in_ready;

  afs_exec u_exec (
    .opcode           (s1_opcode_r),
    .operand_a        (s1_a_r),
    .operand_b        (s1_b_r),
    .carry_in         (s1_cin_r),
    .cond_code        (s1_cc_r),
    .force_sign_clear (s1_fsc_r),
    .io_data_top      (s1_iotop_r),
    .flags_cur        (flags_r),
    .pointer_cur      (ptr_r),
    .ex               (ex)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode_r <= in_opcode;
      s1_a_r      <= in_operand_a;
      s1_b_r      <= in_operand_b;
      s1_cin_r    <= in_carry_in;
      s1_cc_r     <= in_cond_code;
      s1_fsc_r    <= in_force_sign_clear;
      s1_iotop_r  <= in_io_data_top;
    end
  end

  // Architectural state: commit as the item leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      q_r     <= '0;
      ptr_r   <= '0;
    end else if (s1_adv) begin
      flags_r <= ex.flags;
      ptr_r   <= ex.pointer;
      if (ex.set_q) begin
        q_r <= ex.flags;
      end else if (ex.clr_q) begin
        q_r <= '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_result_r <= ex.result;
      out_flags_r  <= ex.flags;
      out_met_r    <= ex.met;
      out_ptr_r    <= ex.pointer;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result        = out_result_r;
  assign out_flags_out     = out_flags_r;
  assign out_condition_met = out_met_r;
  assign out_pointer_out   = out_ptr_r;

  `AFS_ASSERT_NXT(a_q_tracks_flags, s1_adv && ex.set_q, q_r == flags_r,
                  "Q copy differs from flags after a flag-setting item")
  `AFS_ASSERT_NXT(a_q_cleared, s1_adv && ex.clr_q, q_r == 8'd0,
                  "Q copy not cleared")
  `AFS_ASSERT_NXT(a_state_hold, !s1_adv, $stable(flags_r) && $stable(ptr_r),
                  "state changed without an item moving")
  `AFS_ASSERT_NXT(a_out_matches_state, s1_adv,
                  out_flags_r == flags_r && out_ptr_r == ptr_r,
                  "result register disagrees with committed state")

endmodule

// File: dv/tb_alu_with_status_flags_core.sv
// Self-checking testbench for alu_with_status_flags_core: a directed table, then random items.
// Depends on afs_pkg and the core RTL; a built-in predictor supplies the expected results.
`timescale 1ns / 1ps

module tb_alu_with_status_flags_core;
  import afs_pkg::*;

  localparam logic [3:0] OP_UNUSED = 4'd15;
  localparam int RANDOM_ITEMS = 1950;

  localparam logic [7:0] M_S = 8'h01 << FL_S;
  localparam logic [7:0] M_Z = 8'h01 << FL_Z;
  localparam logic [7:0] M_Y = 8'h01 << FL_Y;
  localparam logic [7:0] M_H = 8'h01 << FL_H;
  localparam logic [7:0] M_X = 8'h01 << FL_X;
  localparam logic [7:0] M_P = 8'h01 << FL_P;
  localparam logic [7:0] M_N = 8'h01 << FL_N;
  localparam logic [7:0] M_C = 8'h01 << FL_C;

  typedef struct packed {
    logic [3:0]  op;
    logic [15:0] a;
    logic [15:0] b;
    logic        cin;
    logic [2:0]  cc;
    logic        fsc;
    logic        iotop;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  flags;
    logic        met;
    logic [15:0] pointer;
  } alu_rsp_t;

  typedef struct packed {
    alu_req_t rq;
    logic     typed;
    alu_rsp_t rsp;
  } dir_row_t;

  localparam alu_rsp_t NO_RSP = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_opcode = '0;
  logic [15:0] in_operand_a = '0;
  logic [15:0] in_operand_b = '0;
  logic        in_carry_in = 1'b0;
  logic [2:0]  in_cond_code = '0;
  logic        in_force_sign_clear = 1'b0;
  logic        in_io_data_top = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_result;
  logic [7:0]  out_flags_out;
  logic        out_condition_met;
  logic [15:0] out_pointer_out;

  // Predictor state: flags, Q copy and memory pointer as the block should hold them
  logic [7:0]  pred_flags = '0;
  logic [7:0]  pred_q = '0;
  logic [15:0] pred_ptr = '0;

  alu_rsp_t results_due[$];
  dir_row_t dir_tbl[$];
  alu_rsp_t got_rsp, want_rsp;
  int       idle_pct = 23;
  int       mismatch_cnt = 0;

  alu_with_status_flags_core u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] parity_flag(logic [7:0] v);
    return (^v) ? 8'h00 : M_P;
  endfunction

  function automatic logic [7:0] szxy_flags(logic [7:0] r);
    return (r & (M_S | M_Y | M_X)) | ((r == 8'h00) ? M_Z : 8'h00);
  endfunction

  // Execute one operation on the predictor state and return what the block should emit
  function automatic alu_rsp_t compute_alu(alu_req_t rq);
    logic [7:0]  a8, b8, f, r8, sel;
    logic [8:0]  r9;
    logic [16:0] r17;
    logic        ovf, hc, hit, load_q;
    alu_rsp_t    rsp;
    a8 = rq.a[7:0];
    b8 = rq.b[7:0];
    f = pred_flags;
    rsp = '0;
    load_q = 1'b1;
    case (rq.op)
      OP_ADD8: begin
        r9 = a8 + b8 + rq.cin;
        ovf = ~(a8[7] ^ b8[7]) & (a8[7] ^ r9[7]);
        f = szxy_flags(r9[7:0]) | ((a8 ^ b8 ^ r9[7:0]) & M_H) | (ovf ? M_P : 8'h00)
            | (r9[8] ? M_C : 8'h00);
        rsp.result = {8'h00, r9[7:0]};
      end
      OP_SUB8, OP_CMP: begin
        r9 = a8 - b8 - ((rq.op == OP_SUB8) ? rq.cin : 1'b0);
        ovf = (a8[7] ^ b8[7]) & (a8[7] ^ r9[7]);
        f = szxy_flags(r9[7:0]) | ((a8 ^ b8 ^ r9[7:0]) & M_H) | (ovf ? M_P : 8'h00)
            | M_N | (r9[8] ? M_C : 8'h00);
        // compare takes X and Y from the operand, not the difference
        if (rq.op == OP_CMP) f = (f & ~(M_Y | M_X)) | (b8 & (M_Y | M_X));
        rsp.result = {8'h00, r9[7:0]};
      end
      OP_AND, OP_OR, OP_XOR: begin
        r8 = (rq.op == OP_AND) ? (a8 & b8) : (rq.op == OP_OR) ? (a8 | b8) : (a8 ^ b8);
        f = szxy_flags(r8) | parity_flag(r8) | ((rq.op == OP_AND) ? M_H : 8'h00);
        rsp.result = {8'h00, r8};
      end
      OP_INC: begin
        r8 = b8 + 8'h01;
        f = szxy_flags(r8) | ((b8[3:0] == 4'hF) ? M_H : 8'h00)
            | ((b8 == 8'h7F) ? M_P : 8'h00) | (f & M_C);
        rsp.result = {8'h00, r8};
      end
      OP_DEC: begin
        r8 = b8 - 8'h01;
        f = szxy_flags(r8) | ((b8[3:0] == 4'h0) ? M_H : 8'h00)
            | ((b8 == 8'h80) ? M_P : 8'h00) | M_N | (f & M_C);
        rsp.result = {8'h00, r8};
      end
      OP_ADD16, OP_ADC16, OP_SBC16: begin
        if (rq.op == OP_SBC16) begin
          r17 = rq.a - rq.b - rq.cin;
          ovf = (rq.a[15] ^ rq.b[15]) & (rq.a[15] ^ r17[15]);
        end else begin
          r17 = rq.a + rq.b + ((rq.op == OP_ADC16) ? rq.cin : 1'b0);
          ovf = ~(rq.a[15] ^ rq.b[15]) & (rq.a[15] ^ r17[15]);
        end
        hc = rq.a[12] ^ rq.b[12] ^ r17[12];
        // plain 16-bit add keeps S, Z and P
        if (rq.op == OP_ADD16) f &= (M_S | M_Z | M_P);
        else f = (r17[15] ? M_S : 8'h00) | ((r17[15:0] == 16'h0) ? M_Z : 8'h00)
                 | (ovf ? M_P : 8'h00) | ((rq.op == OP_SBC16) ? M_N : 8'h00);
        f |= (hc ? M_H : 8'h00) | (r17[16] ? M_C : 8'h00) | (r17[15:8] & (M_Y | M_X));
        rsp.result = r17[15:0];
        pred_ptr = rq.a + 16'h0001;
      end
      OP_ROTFLAGS: begin
        f = szxy_flags(b8) | parity_flag(b8) | (f & M_C);
        if (rq.fsc) f &= ~M_S;
      end
      OP_IOFLAGS: begin
        f &= (M_S | M_Z | M_Y | M_X);
        if (rq.b[15:8] != 8'h00) f |= (M_H | M_C);
        f |= parity_flag({5'b0, rq.b[2:0]} ^ a8);
        if (rq.iotop) f |= M_N;
      end
      OP_COND: begin
        case (rq.cc[2:1])
          CC_ZERO:   sel = M_Z;
          CC_CARRY:  sel = M_C;
          CC_PARITY: sel = M_P;
          default:   sel = M_S;
        endcase
        hit = (f & sel) != 8'h00;
        rsp.met = rq.cc[0] ? hit : ~hit;
        load_q = 1'b0;
      end
      OP_CLEARQ: begin
        pred_q = 8'h00;
        load_q = 1'b0;
      end
      default: load_q = 1'b0;
    endcase
    pred_flags = f;
    if (load_q) pred_q = f;
    rsp.flags = pred_flags;
    rsp.pointer = pred_ptr;
    return rsp;
  endfunction

  function automatic alu_req_t mk_req(logic [3:0] op, logic [15:0] a, logic [15:0] b,
                                      logic cin, logic [2:0] cc, logic fsc, logic iotop);
    return {op, a, b, cin, cc, fsc, iotop};
  endfunction

  // Bias operands toward the carry and overflow boundaries
  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(9))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v[7:0] = 8'h7F + 8'($urandom_range(1));
      3: v = 16'h7FFF + 16'($urandom_range(1));
      4: v[15:8] = 8'h00;
      5: v[3:0] = ($urandom_range(1) != 0) ? 4'hF : 4'h0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic alu_req_t random_req();
    logic [3:0] op;
    op = ($urandom_range(63) == 0) ? OP_UNUSED : 4'($urandom_range(14));
    return mk_req(op, pick_operand(), pick_operand(), 1'($urandom), 3'($urandom),
                  1'($urandom), 1'($urandom));
  endfunction

  // Present one item from a falling edge; return at the falling edge after it is taken
  task automatic drive_item(alu_req_t rq, logic typed, alu_rsp_t typed_rsp);
    alu_rsp_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= rq.op;
    in_operand_a <= rq.a;
    in_operand_b <= rq.b;
    in_carry_in <= rq.cin;
    in_cond_code <= rq.cc;
    in_force_sign_clear <= rq.fsc;
    in_io_data_top <= rq.iotop;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = compute_alu(rq);
    results_due.push_back(typed ? typed_rsp : pred);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_rsp = {out_result, out_flags_out, out_condition_met, out_pointer_out};
      if (results_due.size() == 0) begin
        $error("result item with none expected: %h", got_rsp);
        mismatch_cnt++;
      end else begin
        want_rsp = results_due.pop_front();
        if (got_rsp.result !== want_rsp.result) begin
          $error("result: expected %h, got %h", want_rsp.result, got_rsp.result);
          mismatch_cnt++;
        end
        if (got_rsp.flags !== want_rsp.flags) begin
          $error("flags_out: expected %h, got %h", want_rsp.flags, got_rsp.flags);
          mismatch_cnt++;
        end
        if (got_rsp.met !== want_rsp.met) begin
          $error("condition_met: expected %b, got %b", want_rsp.met, got_rsp.met);
          mismatch_cnt++;
        end
        if (got_rsp.pointer !== want_rsp.pointer) begin
          $error("pointer_out: expected %h, got %h", want_rsp.pointer, got_rsp.pointer);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    int n;
    int drain;
    // Typed rows hold state that is obvious from reset; the rest go through the predictor
    dir_tbl.push_back({mk_req(OP_COND, 16'h0000, 16'h0000, 1'b0, 3'd1, 1'b0, 1'b0), 1'b1,
                       {16'h0000, 8'h00, 1'b0, 16'h0000}});
    dir_tbl.push_back({mk_req(OP_COND, 16'hFFFF, 16'hFFFF, 1'b1, 3'd0, 1'b1, 1'b1), 1'b1,
                       {16'h0000, 8'h00, 1'b1, 16'h0000}});
    dir_tbl.push_back({mk_req(OP_ADD8, 16'hFF00, 16'hFF00, 1'b0, 3'd0, 1'b0, 1'b0), 1'b1,
                       {16'h0000, 8'h40, 1'b0, 16'h0000}});
    dir_tbl.push_back({mk_req(OP_ADD8, 16'h00FF, 16'h00FF, 1'b1, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_ADD8, 16'h007F, 16'h0000, 1'b1, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_SUB8, 16'h0000, 16'h00FF, 1'b1, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_SUB8, 16'h0080, 16'h0000, 1'b1, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_AND, 16'hFFFF, 16'hFFFF, 1'b0, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_OR, 16'hAB00, 16'hCD00, 1'b1, 3'd0, 1'b0, 1'b0), 1'b1,
                       {16'h0000, 8'h44, 1'b0, 16'h0000}});
    dir_tbl.push_back({mk_req(OP_XOR, 16'h00AA, 16'h0055, 1'b0, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_CMP, 16'h0000, 16'h0028, 1'b1, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_INC, 16'h0000, 16'h007F, 1'b0, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_INC, 16'h0000, 16'hFFFF, 1'b0, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_DEC, 16'h0000, 16'h0080, 1'b0, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_DEC, 16'h0000, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_ADD16, 16'hFFFF, 16'h0001, 1'b1, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_ADC16, 16'h7FFF, 16'h0000, 1'b1, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_SBC16, 16'h0000, 16'hFFFF, 1'b1, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_ROTFLAGS, 16'h0000, 16'h0080, 1'b0, 3'd0, 1'b1, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_IOFLAGS, 16'h00FF, 16'h01FF, 1'b0, 3'd0, 1'b0, 1'b1), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_IOFLAGS, 16'h0000, 16'h00FF, 1'b0, 3'd0, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_COND, 16'h0000, 16'h0000, 1'b0, 3'd7, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_COND, 16'h0000, 16'h0000, 1'b0, 3'd4, 1'b0, 1'b0), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_CLEARQ, 16'h1234, 16'h5678, 1'b1, 3'd3, 1'b1, 1'b1), 1'b0,
                       NO_RSP});
    dir_tbl.push_back({mk_req(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 3'd7, 1'b1, 1'b1), 1'b0,
                       NO_RSP});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) drive_item(dir_tbl[i].rq, dir_tbl[i].typed, dir_tbl[i].rsp);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // hold both sides busy through one long stretch
      idle_pct = (n >= 700 && n < 1000) ? 0 : 23;
      drive_item(random_req(), 1'b0, NO_RSP);
    end
    in_valid <= 1'b0;

    drain = 0;
    while (results_due.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d result items never arrived", results_due.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
